// ===== rtl/mrsp_pkg.sv =====
// ----------------------------------------------------------------------------
// MIDI running status parser package
// Shared types and constants for the parser front end, job queue and
// echo sequencer.
// ----------------------------------------------------------------------------
package mrsp_pkg;

   // Message type nibbles (upper nibble of a status byte).
   localparam logic [3:0] TYPE_NOTE_OFF  = 4'h8;
   localparam logic [3:0] TYPE_NOTE_ON   = 4'h9;
   localparam logic [3:0] TYPE_POLY_AT   = 4'hA;
   localparam logic [3:0] TYPE_CTRL      = 4'hB;
   localparam logic [3:0] TYPE_PROGRAM   = 4'hC;
   localparam logic [3:0] TYPE_CHAN_AT   = 4'hD;
   localparam logic [3:0] TYPE_PITCH     = 4'hE;
   localparam logic [3:0] TYPE_SYSTEM    = 4'hF;

   // Marker bytes sent ahead of every completed message.
   localparam logic [7:0] MARK_HEAD      = 8'h9F;
   localparam logic [7:0] MARK_FILL      = 8'hAA;

   // Job queue geometry.
   localparam int unsigned QUEUE_DEPTH   = 2;
   localparam int unsigned QUEUE_PTR_W   = 1;

   typedef enum logic {
      JOB_ECHO,
      JOB_MSG
   } job_kind_type;

   // One unit of work handed from the front end to the echo sequencer.
   typedef struct packed {
      job_kind_type kind;
      logic [7:0]   echo_byte;
      logic [3:0]   msg_type;
      logic [3:0]   msg_chan;
      logic [6:0]   data0;
      logic [6:0]   data1;
      logic         two_data;
      logic         is_note;
      logic         note_on;
      logic         show_body;
   } job_type;

   // Position inside the output sequence of a completed message.
   typedef enum logic [2:0] {
      STEP_HEAD   = 3'd0,
      STEP_FILL1  = 3'd1,
      STEP_FILL2  = 3'd2,
      STEP_STATUS = 3'd3,
      STEP_DATA0  = 3'd4,
      STEP_DATA1  = 3'd5
   } step_type;

endpackage

// ===== rtl/mrsp_front.sv =====
// ----------------------------------------------------------------------------
// MIDI parser front end
// Tracks the open message and running status, and turns each accepted
// byte into at most one job for the echo sequencer.
// ----------------------------------------------------------------------------
module mrsp_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [7:0]       midi_byte,
   input  logic             csr_wr_en,
   input  logic             csr_wr_data,
   output logic             job_push,
   output mrsp_pkg::job_type job
);

   logic [3:0] cur_type_ff, cur_type_in;
   logic [3:0] cur_chan_ff, cur_chan_in;
   logic [1:0] cur_left_ff, cur_left_in;
   logic [1:0] cur_count_ff, cur_count_in;
   logic [6:0] first_data_ff, first_data_in;
   logic [3:0] run_type_ff, run_type_in;
   logic [3:0] run_chan_ff, run_chan_in;
   logic [1:0] run_need_ff, run_need_in;
   logic       ignore_ff, ignore_in;
   logic       mute_ff, mute_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_type_ff   <= '0;
         cur_chan_ff   <= '0;
         cur_left_ff   <= '0;
         cur_count_ff  <= '0;
         first_data_ff <= '0;
         run_type_ff   <= '0;
         run_chan_ff   <= '0;
         run_need_ff   <= '0;
         ignore_ff     <= 1'b0;
         mute_ff       <= 1'b0;
      end else begin
         cur_type_ff   <= cur_type_in;
         cur_chan_ff   <= cur_chan_in;
         cur_left_ff   <= cur_left_in;
         cur_count_ff  <= cur_count_in;
         first_data_ff <= first_data_in;
         run_type_ff   <= run_type_in;
         run_chan_ff   <= run_chan_in;
         run_need_ff   <= run_need_in;
         ignore_ff     <= ignore_in;
         mute_ff       <= mute_in;
      end
   end

   assign mute_in = csr_wr_en ? csr_wr_data : mute_ff;

   always_comb begin
      logic [3:0] eff_type;
      logic [3:0] eff_chan;
      logic [1:0] eff_left;
      logic [1:0] eff_count;
      logic [6:0] eff_first;
      logic [1:0] left_next;
      logic       two;
      logic [6:0] d0;
      logic [6:0] d1;
      logic       note;

      cur_type_in   = cur_type_ff;
      cur_chan_in   = cur_chan_ff;
      cur_left_in   = cur_left_ff;
      cur_count_in  = cur_count_ff;
      first_data_in = first_data_ff;
      run_type_in   = run_type_ff;
      run_chan_in   = run_chan_ff;
      run_need_in   = run_need_ff;
      ignore_in     = ignore_ff;
      job_push      = 1'b0;
      job           = '0;
      job.kind      = mrsp_pkg::JOB_ECHO;
      job.echo_byte = midi_byte;

      // With nothing open, a data byte picks up the saved running status.
      if (cur_left_ff == 2'd0) begin
         eff_type  = run_type_ff;
         eff_chan  = run_chan_ff;
         eff_left  = run_need_ff;
         eff_count = 2'd0;
         eff_first = 7'd0;
      end else begin
         eff_type  = cur_type_ff;
         eff_chan  = cur_chan_ff;
         eff_left  = cur_left_ff;
         eff_count = cur_count_ff;
         eff_first = first_data_ff;
      end
      left_next = eff_left - 2'd1;
      two       = (eff_count != 2'd0);
      d0        = two ? eff_first : midi_byte[6:0];
      d1        = two ? midi_byte[6:0] : 7'd0;
      note      = (eff_type == mrsp_pkg::TYPE_NOTE_OFF) ||
                  (eff_type == mrsp_pkg::TYPE_NOTE_ON);

      if (accept) begin
         if (midi_byte[7]) begin
            cur_left_in   = 2'd0;
            cur_count_in  = 2'd0;
            first_data_in = 7'd0;
            if (midi_byte[7:4] == mrsp_pkg::TYPE_SYSTEM) begin
               cur_type_in = 4'd0;
               cur_chan_in = 4'd0;
               ignore_in   = 1'b1;
               job_push    = 1'b1;
            end else begin
               cur_type_in = midi_byte[7:4];
               cur_chan_in = midi_byte[3:0];
               ignore_in   = 1'b0;
               unique case (midi_byte[7:4]) inside
                  mrsp_pkg::TYPE_NOTE_OFF, mrsp_pkg::TYPE_NOTE_ON,
                  mrsp_pkg::TYPE_POLY_AT, mrsp_pkg::TYPE_CTRL,
                  mrsp_pkg::TYPE_PITCH:   cur_left_in = 2'd2;
                  mrsp_pkg::TYPE_PROGRAM,
                  mrsp_pkg::TYPE_CHAN_AT: cur_left_in = 2'd1;
                  default:                cur_left_in = 2'd0;
               endcase
            end
         end else begin
            cur_type_in   = eff_type;
            cur_chan_in   = eff_chan;
            cur_left_in   = eff_left;
            cur_count_in  = eff_count;
            first_data_in = eff_first;
            if (eff_left == 2'd0) begin
               // No status to apply: the byte goes out alone.
               job_push = 1'b1;
            end else if (left_next != 2'd0) begin
               cur_left_in  = left_next;
               cur_count_in = eff_count + 2'd1;
               if (eff_count == 2'd0) begin
                  first_data_in = midi_byte[6:0];
               end
            end else if (ignore_ff) begin
               // Message completes inside a system stream: echo the byte only.
               cur_left_in = 2'd0;
               job_push    = 1'b1;
            end else begin
               job_push       = 1'b1;
               job.kind       = mrsp_pkg::JOB_MSG;
               job.msg_type   = eff_type;
               job.msg_chan   = eff_chan;
               job.data0      = d0;
               job.data1      = d1;
               job.two_data   = two;
               job.is_note    = note;
               job.note_on    = (eff_type == mrsp_pkg::TYPE_NOTE_ON) && (d1 != 7'd0);
               job.show_body  = !(note && mute_ff);
               run_type_in    = eff_type;
               run_chan_in    = eff_chan;
               run_need_in    = two ? 2'd2 : 2'd1;
               cur_type_in    = 4'd0;
               cur_chan_in    = 4'd0;
               cur_left_in    = 2'd0;
               cur_count_in   = 2'd0;
               first_data_in  = 7'd0;
            end
         end
      end
   end

endmodule

// ===== rtl/mrsp_queue.sv =====
// ----------------------------------------------------------------------------
// MIDI parser job queue
// Small first-in first-out buffer that decouples the front end from the
// echo sequencer.
// ----------------------------------------------------------------------------
module mrsp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  mrsp_pkg::job_type push_job,
   input  logic              pop,
   output mrsp_pkg::job_type head_job,
   output logic              not_empty,
   output logic              full
);

   mrsp_pkg::job_type                    entry_ff [mrsp_pkg::QUEUE_DEPTH];
   logic [mrsp_pkg::QUEUE_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [mrsp_pkg::QUEUE_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [mrsp_pkg::QUEUE_PTR_W:0]       count_ff, count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   assign head_job  = entry_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == (mrsp_pkg::QUEUE_PTR_W + 1)'(mrsp_pkg::QUEUE_DEPTH));

endmodule

// ===== rtl/mrsp_back.sv =====
// ----------------------------------------------------------------------------
// MIDI parser echo sequencer
// Expands each queued job into its result bytes, one per cycle while
// rsp_stall is low, through an output register.
// ----------------------------------------------------------------------------
module mrsp_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   input  mrsp_pkg::job_type job,
   output logic              job_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_is_last,
   output logic              rsp_note_event,
   output logic [3:0]        rsp_note_channel,
   output logic [6:0]        rsp_note_number,
   output logic [6:0]        rsp_note_velocity,
   output logic              rsp_note_is_on
);

   mrsp_pkg::step_type step_ff, step_in;
   logic               valid_ff, valid_in;
   logic [7:0]         byte_ff, byte_in;
   logic               last_ff, last_in;
   logic               event_ff, event_in;
   logic [3:0]         chan_ff, chan_in;
   logic [6:0]         number_ff, number_in;
   logic [6:0]         velocity_ff, velocity_in;
   logic               on_ff, on_in;
   logic               load;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= mrsp_pkg::STEP_HEAD;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff     <= byte_in;
      last_ff     <= last_in;
      event_ff    <= event_in;
      chan_ff     <= chan_in;
      number_ff   <= number_in;
      velocity_ff <= velocity_in;
      on_ff       <= on_in;
   end

   assign load = job_valid && (!valid_ff || !rsp_stall);

   always_comb begin
      logic [7:0]         cur_byte;
      logic               cur_last;
      mrsp_pkg::step_type next_step;

      cur_byte  = mrsp_pkg::MARK_HEAD;
      cur_last  = 1'b0;
      next_step = mrsp_pkg::STEP_HEAD;
      unique case (step_ff)
         mrsp_pkg::STEP_HEAD: begin
            cur_byte  = mrsp_pkg::MARK_HEAD;
            next_step = mrsp_pkg::STEP_FILL1;
         end
         mrsp_pkg::STEP_FILL1: begin
            cur_byte  = mrsp_pkg::MARK_FILL;
            next_step = mrsp_pkg::STEP_FILL2;
         end
         mrsp_pkg::STEP_FILL2: begin
            cur_byte  = mrsp_pkg::MARK_FILL;
            cur_last  = !job.show_body;
            next_step = mrsp_pkg::STEP_STATUS;
         end
         mrsp_pkg::STEP_STATUS: begin
            cur_byte  = {job.msg_type, job.msg_chan};
            next_step = mrsp_pkg::STEP_DATA0;
         end
         mrsp_pkg::STEP_DATA0: begin
            cur_byte  = {1'b0, job.data0};
            cur_last  = !job.two_data;
            next_step = mrsp_pkg::STEP_DATA1;
         end
         mrsp_pkg::STEP_DATA1: begin
            cur_byte  = {1'b0, job.data1};
            cur_last  = 1'b1;
            next_step = mrsp_pkg::STEP_HEAD;
         end
         default: begin
            cur_byte  = mrsp_pkg::MARK_HEAD;
            cur_last  = 1'b1;
            next_step = mrsp_pkg::STEP_HEAD;
         end
      endcase
      if (job.kind == mrsp_pkg::JOB_ECHO) begin
         cur_byte = job.echo_byte;
         cur_last = 1'b1;
      end

      step_in     = step_ff;
      valid_in    = valid_ff && rsp_stall;
      byte_in     = byte_ff;
      last_in     = last_ff;
      event_in    = event_ff;
      chan_in     = chan_ff;
      number_in   = number_ff;
      velocity_in = velocity_ff;
      on_in       = on_ff;
      job_pop     = 1'b0;

      if (load) begin
         valid_in    = 1'b1;
         byte_in     = cur_byte;
         last_in     = cur_last;
         event_in    = 1'b0;
         chan_in     = 4'd0;
         number_in   = 7'd0;
         velocity_in = 7'd0;
         on_in       = 1'b0;
         if (job.kind == mrsp_pkg::JOB_MSG && job.is_note &&
             step_ff == mrsp_pkg::STEP_HEAD) begin
            event_in    = 1'b1;
            chan_in     = job.msg_chan;
            number_in   = job.data0;
            velocity_in = job.data1;
            on_in       = job.note_on;
         end
         step_in = cur_last ? mrsp_pkg::STEP_HEAD : next_step;
         job_pop = cur_last;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_out_byte      = byte_ff;
   assign rsp_is_last       = last_ff;
   assign rsp_note_event    = event_ff;
   assign rsp_note_channel  = chan_ff;
   assign rsp_note_number   = number_ff;
   assign rsp_note_velocity = velocity_ff;
   assign rsp_note_is_on    = on_ff;

endmodule

// ===== rtl/midi_running_status_parser_core.sv =====
// ----------------------------------------------------------------------------
// MIDI running status parser core
// Parses a MIDI byte stream with running status and produces an echo
// stream with marked, completed channel messages and note events.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake             Payload
//   req_      in         req_valid/req_stall   req_midi_byte
//   rsp_      out        rsp_valid/rsp_stall   rsp_out_byte, rsp_is_last,
//                                              rsp_note_* fields
//   csr_      in         csr_wr_en             csr_wr_data (mute_note_echo)
//
// A request is classified in the cycle it is accepted and its job is written
// into the queue. The first result is then loaded from the queue head into
// the rsp_ output register, from which the port takes it. The sequencer sends
// one result per cycle while rsp_stall is low, so a request gives one, three,
// five or six results on the output port.
// Requests are taken every cycle while the two-entry job queue has room;
// req_stall rises only when it is full. Requests that give no result
// (channel status bytes, buffered data bytes) never enter the queue.
// Reset is synchronous and clears the parser state, the queue and rsp_valid.
//
module midi_running_status_parser_core (
   input  logic       clock,
   input  logic       reset,

   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_midi_byte,

   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_is_last,
   output logic       rsp_note_event,
   output logic [3:0] rsp_note_channel,
   output logic [6:0] rsp_note_number,
   output logic [6:0] rsp_note_velocity,
   output logic       rsp_note_is_on,

   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);

   logic              req_accept;
   logic              job_push;
   mrsp_pkg::job_type push_job;
   mrsp_pkg::job_type head_job;
   logic              queue_not_empty;
   logic              queue_full;
   logic              job_pop;

   // The front end only stalls on a full queue; it needs no time of its own.
   assign req_stall  = queue_full;
   assign req_accept = req_valid && !req_stall;

   // Front end: running status tracking and message classification.
   mrsp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .midi_byte   (req_midi_byte),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .job_push    (job_push),
      .job         (push_job)
   );

   // Queue between the two halves, so a stalled output does not hold
   // back the parser until it fills.
   mrsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_job  (push_job),
      .pop       (job_pop),
      .head_job  (head_job),
      .not_empty (queue_not_empty),
      .full      (queue_full)
   );

   // Back end: expands each job into its result bytes.
   mrsp_back u_back (
      .clock             (clock),
      .reset             (reset),
      .job_valid         (queue_not_empty),
      .job               (head_job),
      .job_pop           (job_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_is_last       (rsp_is_last),
      .rsp_note_event    (rsp_note_event),
      .rsp_note_channel  (rsp_note_channel),
      .rsp_note_number   (rsp_note_number),
      .rsp_note_velocity (rsp_note_velocity),
      .rsp_note_is_on    (rsp_note_is_on)
   );

endmodule
